### src/ikl_pkg.sv
// ----------------------------------------------------------------------------
// ikl_pkg
// Shared types and constants of the IMU Kalman and low-pass filter block.
// ----------------------------------------------------------------------------
`default_nettype none

package ikl_pkg;

  localparam int unsigned GAIN_BITS = 16;
  localparam int unsigned GAIN_W    = GAIN_BITS + 1;
  localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << GAIN_BITS;

  localparam int unsigned CFG_W = 24;
  localparam logic [1:0] REG_PROCESS_NOISE = 2'd0;
  localparam logic [1:0] REG_MEASURE_NOISE = 2'd1;
  localparam logic [1:0] REG_SMOOTHING     = 2'd2;

  localparam logic [23:0] PROCESS_NOISE_RST = 24'd3277;
  localparam logic [23:0] MEASURE_NOISE_RST = 24'd327680;
  localparam logic [15:0] SMOOTHING_RST     = 16'd25297;

  localparam int ACC_OUT_LO = -8388608;
  localparam int ACC_OUT_HI = 8388352;
  localparam int GYR_OUT_LO = -16776960;
  localparam int GYR_OUT_HI = 16776960;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV_GO,
    S_DIV_WAIT,
    S_MUL_GO,
    S_MUL_WAIT,
    S_FINISH
  } state_e;

endpackage

`default_nettype wire

### src/ikl_serial_div.sv
// ----------------------------------------------------------------------------
// ikl_serial_div
// Restoring divider that produces one quotient bit per cycle, MSB first.
// ----------------------------------------------------------------------------
`default_nettype none

module ikl_serial_div import ikl_pkg::*; #(
  parameter int unsigned DEN_W = 35,
  parameter int unsigned Q_W   = 17
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start_i,
  input  wire logic [DEN_W+Q_W-1:0]   num_i,
  input  wire logic [DEN_W-1:0]       den_i,
  output logic                        done_o,
  output logic [Q_W-1:0]              quo_o
);

  localparam int unsigned CNT_W = $clog2(Q_W);

  logic [DEN_W-1:0] rem_q, den_q;
  logic [Q_W-1:0]   nlo_q, quo_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q, done_q;
  logic [DEN_W:0]   rem2, diff;
  logic             ge;

  assign rem2 = {rem_q, nlo_q[Q_W-1]};
  assign ge   = rem2 >= {1'b0, den_q};
  assign diff = rem2 - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(Q_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i[DEN_W+Q_W-1:Q_W];
      nlo_q <= num_i[Q_W-1:0];
      den_q <= den_i;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DEN_W-1:0] : rem2[DEN_W-1:0];
      nlo_q <= {nlo_q[Q_W-2:0], 1'b0};
      quo_q <= {quo_q[Q_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

`default_nettype wire

### src/ikl_serial_mul.sv
// ----------------------------------------------------------------------------
// ikl_serial_mul
// Shift-add multiplier: signed multiplicand, unsigned multiplier, one
// multiplier bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ikl_serial_mul import ikl_pkg::*; #(
  parameter int unsigned MC_W = 36,
  parameter int unsigned ML_W = 17
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic signed [MC_W-1:0]        mcand_i,
  input  wire logic [ML_W-1:0]               mult_i,
  output logic                               done_o,
  output logic signed [MC_W+ML_W-1:0]        prod_o
);

  localparam int unsigned P_W   = MC_W + ML_W;
  localparam int unsigned CNT_W = $clog2(ML_W);

  logic signed [P_W-1:0] mc_q, sum_q;
  logic [ML_W-1:0]       ml_q;
  logic [CNT_W-1:0]      cnt_q;
  logic                  busy_q, done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(ML_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mc_q  <= P_W'(mcand_i);
      ml_q  <= mult_i;
      sum_q <= '0;
    end else if (busy_q) begin
      if (ml_q[0]) begin
        sum_q <= sum_q + mc_q;
      end
      mc_q <= mc_q <<< 1;
      ml_q <= ml_q >> 1;
    end
  end

  assign done_o = done_q;
  assign prod_o = sum_q;

endmodule

`default_nettype wire

### src/imu_kalman_lowpass_filter.sv
// ----------------------------------------------------------------------------
// imu_kalman_lowpass_filter
// Scalar Kalman filters on three accelerometer axes with a shared covariance,
// and first-order low-pass filters on three gyro axes.
// ----------------------------------------------------------------------------
//
// Channel  Direction  Handshake                    Payload
// in       input      in_valid_i / in_stall_o      acc_x/y/z, gyro_x/y/z
// out      output     out_valid_o / out_stall_i    acc_*_est, gyro_*_smooth
// cfg      input      cfg_we_i                     cfg_idx_i, cfg_data_i
//
// Each item runs one 17-step serial divide for the gain and seven 17-step serial
// multiplies on one shared shift-add multiplier, and a new item is accepted only
// once the last one is written back. Reset clears the filter state and loads
// the register defaults. A finished result waits in the output register while
// the next item is accepted and worked on; only the final write-back stalls on it.
`default_nettype none

module imu_kalman_lowpass_filter import ikl_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic signed [15:0] acc_x_i,
  input  wire logic signed [15:0] acc_y_i,
  input  wire logic signed [15:0] acc_z_i,
  input  wire logic signed [16:0] gyro_x_i,
  input  wire logic signed [16:0] gyro_y_i,
  input  wire logic signed [16:0] gyro_z_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [23:0]      acc_x_est_o,
  output logic signed [23:0]      acc_y_est_o,
  output logic signed [23:0]      acc_z_est_o,
  output logic signed [24:0]      gyro_x_smooth_o,
  output logic signed [24:0]      gyro_y_smooth_o,
  output logic signed [24:0]      gyro_z_smooth_o,
  input  wire logic               cfg_we_i,
  input  wire logic [1:0]         cfg_idx_i,
  input  wire logic [CFG_W-1:0]   cfg_data_i
);

  localparam int unsigned EST_W = FRAC_BITS + 18;
  localparam int unsigned GYR_W = FRAC_BITS + 19;
  localparam int unsigned MC_W  = (FRAC_BITS + 20 > 36) ? FRAC_BITS + 20 : 36;
  localparam int unsigned P_W   = MC_W + GAIN_W;
  localparam int unsigned PM_W  = 34;
  localparam int unsigned DEN_W = 35;
  localparam int unsigned UP    = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
  localparam int unsigned DN    = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
  localparam int unsigned OSH   = FRAC_BITS - 8;
  localparam logic signed [P_W-1:0] PRND = P_W'(1) << (GAIN_BITS - 1);
  localparam logic signed [EST_W-1:0] ERND = (OSH > 0) ? EST_W'(1) << (OSH - 1) : '0;
  localparam logic signed [GYR_W-1:0] GRND = (OSH > 0) ? GYR_W'(1) << (OSH - 1) : '0;
  localparam logic signed [EST_W-1:0] A_LO = EST_W'(ACC_OUT_LO);
  localparam logic signed [EST_W-1:0] A_HI = EST_W'(ACC_OUT_HI);
  localparam logic signed [GYR_W-1:0] G_LO = GYR_W'(GYR_OUT_LO);
  localparam logic signed [GYR_W-1:0] G_HI = GYR_W'(GYR_OUT_HI);

  state_e state_q, state_d;

  logic [23:0] q_reg_q, r_reg_q;
  logic [15:0] a_reg_q;

  logic signed [EST_W-1:0] acc_q [3];
  logic signed [GYR_W-1:0] gyr_q [3];
  logic [31:0]             cov_q;
  logic signed [15:0]      acc_in_q [3];
  logic signed [16:0]      gyr_in_q [3];
  logic [PM_W-1:0]         pmid_q;
  logic [DEN_W-1:0]        den_q;
  logic [GAIN_W-1:0]       kg_q;
  logic [2:0]              idx_q;

  logic                     div_start, div_done, mul_start, mul_done;
  logic [GAIN_W-1:0]        div_quo;
  logic [DEN_W+GAIN_W-1:0]  div_num;
  logic signed [MC_W-1:0]   mcand;
  logic [GAIN_W-1:0]        mult;
  logic signed [P_W-1:0]    prod, delta;
  logic [PM_W-1:0]          qn, rn, pmid_n;
  logic                     accept, out_free;
  logic [1:0]               gidx;

  assign accept   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_o || !out_stall_i;
  assign qn       = (PM_W'(q_reg_q) << UP) >> DN;
  assign rn       = (PM_W'(r_reg_q) << UP) >> DN;
  assign pmid_n   = PM_W'(cov_q) + qn;
  assign div_num  = ((DEN_W + GAIN_W)'(pmid_q) << GAIN_BITS) + (DEN_W + GAIN_W)'(den_q >> 1);
  assign delta    = (prod + PRND) >>> GAIN_BITS;
  assign gidx     = 2'(idx_q - 3'd4);

  always_comb begin
    mcand = '0;
    mult  = kg_q;
    case (idx_q)
      3'd0, 3'd1, 3'd2: begin
        mcand = (MC_W'(acc_in_q[idx_q[1:0]]) <<< FRAC_BITS) - MC_W'(acc_q[idx_q[1:0]]);
      end
      3'd3: begin
        mcand = MC_W'(pmid_q);
        mult  = GAIN_ONE - kg_q;
      end
      default: begin
        mcand = (MC_W'(gyr_in_q[gidx]) <<< FRAC_BITS) - MC_W'(gyr_q[gidx]);
        mult  = GAIN_W'(a_reg_q);
      end
    endcase
  end

  ikl_serial_div #(.DEN_W(DEN_W), .Q_W(GAIN_W)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (den_q),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  ikl_serial_mul #(.MC_W(MC_W), .ML_W(GAIN_W)) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .mcand_i (mcand),
    .mult_i  (mult),
    .done_o  (mul_done),
    .prod_o  (prod)
  );

  always_comb begin
    state_d    = state_q;
    div_start  = 1'b0;
    mul_start  = 1'b0;
    in_stall_o = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          state_d = S_DIV_GO;
        end
      end
      S_DIV_GO: begin
        div_start = 1'b1;
        state_d   = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (div_done) begin
          state_d = S_MUL_GO;
        end
      end
      S_MUL_GO: begin
        mul_start = 1'b1;
        state_d   = S_MUL_WAIT;
      end
      S_MUL_WAIT: begin
        if (mul_done) begin
          state_d = (idx_q == 3'd6) ? S_FINISH : S_MUL_GO;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      q_reg_q     <= PROCESS_NOISE_RST;
      r_reg_q     <= MEASURE_NOISE_RST;
      a_reg_q     <= SMOOTHING_RST;
      cov_q       <= '0;
      acc_q       <= '{default: '0};
      gyr_q       <= '{default: '0};
      kg_q        <= '0;
      idx_q       <= '0;
      out_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_PROCESS_NOISE: q_reg_q <= cfg_data_i;
          REG_MEASURE_NOISE: r_reg_q <= cfg_data_i;
          REG_SMOOTHING:     a_reg_q <= cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (state_q == S_DIV_WAIT && div_done) begin
        if (den_q == '0) begin
          kg_q <= '0;
        end else begin
          kg_q <= (div_quo > GAIN_ONE) ? GAIN_ONE : div_quo;
        end
        idx_q <= '0;
      end
      if (state_q == S_MUL_WAIT && mul_done) begin
        idx_q <= idx_q + 3'd1;
        case (idx_q)
          3'd0, 3'd1, 3'd2: begin
            acc_q[idx_q[1:0]] <= acc_q[idx_q[1:0]] + EST_W'(delta);
          end
          3'd3: begin
            cov_q <= (delta > P_W'(33'h0_FFFF_FFFF)) ? 32'hFFFF_FFFF : delta[31:0];
          end
          default: begin
            gyr_q[gidx] <= gyr_q[gidx] + GYR_W'(delta);
          end
        endcase
      end
      if (state_q == S_FINISH && out_free) begin
        out_valid_o <= 1'b1;
      end else if (out_valid_o && !out_stall_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  function automatic logic signed [23:0] acc_out(input logic signed [EST_W-1:0] v);
    logic signed [EST_W-1:0] r;
    r = (v + ERND) >>> OSH;
    if (r < A_LO) r = A_LO;
    else if (r > A_HI) r = A_HI;
    return r[23:0];
  endfunction

  function automatic logic signed [24:0] gyr_out(input logic signed [GYR_W-1:0] v);
    logic signed [GYR_W-1:0] r;
    r = (v + GRND) >>> OSH;
    if (r < G_LO) r = G_LO;
    else if (r > G_HI) r = G_HI;
    return r[24:0];
  endfunction

  always_ff @(posedge clk_i) begin
    if (accept) begin
      acc_in_q[0] <= acc_x_i;
      acc_in_q[1] <= acc_y_i;
      acc_in_q[2] <= acc_z_i;
      gyr_in_q[0] <= gyro_x_i;
      gyr_in_q[1] <= gyro_y_i;
      gyr_in_q[2] <= gyro_z_i;
      pmid_q      <= pmid_n;
      den_q       <= DEN_W'(pmid_n) + DEN_W'(rn);
    end
    if (state_q == S_FINISH && out_free) begin
      acc_x_est_o     <= acc_out(acc_q[0]);
      acc_y_est_o     <= acc_out(acc_q[1]);
      acc_z_est_o     <= acc_out(acc_q[2]);
      gyro_x_smooth_o <= gyr_out(gyr_q[0]);
      gyro_y_smooth_o <= gyr_out(gyr_q[1]);
      gyro_z_smooth_o <= gyr_out(gyr_q[2]);
    end
  end

  a_gain_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    kg_q <= GAIN_ONE)
    else $error("Kalman gain above one.");

  a_accept_starts_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == S_DIV_GO)
    else $error("Accepted item did not start the gain divide.");

  a_finish_delivers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FINISH && out_free) |=> out_valid_o)
    else $error("Finished item was not presented.");

  a_cov_only_at_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(state_q == S_MUL_WAIT && mul_done && idx_q == 3'd3) |=> $stable(cov_q))
    else $error("Covariance changed outside its update.");

endmodule

`default_nettype wire
